@@ rtl/core/iuup_frame_crc_engine_macros.svh @@
// ----------------------------------------------------------------------------
// IuUP frame CRC engine assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef IUUP_FRAME_CRC_ENGINE_MACROS_SVH
`define IUUP_FRAME_CRC_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IUUP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iuup_frame_crc_engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IUUP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iuup_frame_crc_engine: next-cycle check failed");

`endif

@@ rtl/core/iuup_crc_pkg.sv @@
// ----------------------------------------------------------------------------
// IuUP CRC package
// Constants, status codes and byte-wide CRC update functions.
// ----------------------------------------------------------------------------
package iuup_crc_pkg;

    localparam int unsigned MAX_PAYLOAD_BYTES = 1024;

    localparam int CNT_W   = 11;
    localparam int CMP_W   = 17;
    localparam int HCRC_W  = 6;
    localparam int PCRC_W  = 10;

    localparam logic [CNT_W-1:0]  COUNT_MAX  = 11'd2047;
    localparam logic [CNT_W-1:0]  PAY_OFFSET = 11'd4;
    localparam logic [HCRC_W-1:0] HDR_POLY   = 6'd47;
    localparam logic [PCRC_W-1:0] PAY_POLY   = 10'd563;

    localparam logic [3:0] TYPE_DATA_0  = 4'd0;
    localparam logic [3:0] TYPE_ONE     = 4'd1;
    localparam logic [3:0] TYPE_DATA_14 = 4'd14;

    typedef logic [2:0] pay_status_t;

    localparam pay_status_t PAY_OK         = 3'd0;
    localparam pay_status_t PAY_TYPE_ONE   = 3'd1;
    localparam pay_status_t PAY_UNKNOWN    = 3'd2;
    localparam pay_status_t PAY_TOO_SHORT  = 3'd3;
    localparam pay_status_t PAY_TOO_LONG   = 3'd4;

    localparam logic HDR_OK    = 1'b0;
    localparam logic HDR_SHORT = 1'b1;

    // MSB-first CRC-6 over one byte.
    function automatic logic [HCRC_W-1:0] crc6_byte(input logic [HCRC_W-1:0] crc_in,
                                                    input logic [7:0] data);
        logic [HCRC_W-1:0] crc;
        crc = crc_in;
        for (int k = 7; k >= 0; k--)
        begin
            if (crc[HCRC_W-1] ^ data[k])
                crc = {crc[HCRC_W-2:0], 1'b0} ^ HDR_POLY;
            else
                crc = {crc[HCRC_W-2:0], 1'b0};
        end
        return crc;
    endfunction

    // MSB-first CRC-10 over one byte.
    function automatic logic [PCRC_W-1:0] crc10_byte(input logic [PCRC_W-1:0] crc_in,
                                                     input logic [7:0] data);
        logic [PCRC_W-1:0] crc;
        crc = crc_in;
        for (int k = 7; k >= 0; k--)
        begin
            if (crc[PCRC_W-1] ^ data[k])
                crc = {crc[PCRC_W-2:0], 1'b0} ^ PAY_POLY;
            else
                crc = {crc[PCRC_W-2:0], 1'b0};
        end
        return crc;
    endfunction

    function automatic logic has_payload_crc(input logic [3:0] ftype);
        return (ftype == TYPE_DATA_0) || (ftype == TYPE_DATA_14);
    endfunction

endpackage

@@ rtl/core/iuup_frame_crc_engine.sv @@
// ----------------------------------------------------------------------------
// IuUP frame CRC engine
// Takes an IuUP frame one byte per cycle, MSB first, with a mark on the last
// byte, and returns the header CRC-6 over bytes 0 and 1 and the payload
// CRC-10 over the bytes from offset 4 (frame types 0 and 14), together with
// a header status and a payload status. One result word is produced for
// each frame, at its last byte. The block accepts one byte every cycle;
// a byte passes through an input register and then the per-byte CRC update,
// and a frame's last byte then loads the result register behind the outputs.
// Input stalls only when a last byte is waiting and the result register
// still holds an untaken result. Payloads longer than MAX_PAYLOAD_BYTES
// (package constant) report the too-long status.
// ----------------------------------------------------------------------------
`include "iuup_frame_crc_engine_macros.svh"

module iuup_frame_crc_engine
    import iuup_crc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              frame_valid,
    output logic              frame_stall,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,

    output logic              result_valid,
    input  logic              result_stall,
    output logic [HCRC_W-1:0] header_crc,
    output logic [PCRC_W-1:0] payload_crc,
    output logic              header_status,
    output logic [2:0]        payload_status
);

    logic              in_valid_reg;
    logic [7:0]        in_data_reg;
    logic              in_last_reg;

    logic [CNT_W-1:0]  byte_count_reg,        byte_count_next;
    logic [3:0]        frame_type_reg,        frame_type_next;
    logic [HCRC_W-1:0] header_remainder_reg,  header_remainder_next;
    logic [PCRC_W-1:0] payload_remainder_reg, payload_remainder_next;
    logic              overflow_flag_reg,     overflow_flag_next;

    logic              result_valid_reg,      result_valid_next;
    logic [HCRC_W-1:0] header_crc_reg,        header_crc_next;
    logic [PCRC_W-1:0] payload_crc_reg,       payload_crc_next;
    logic              header_status_reg,     header_status_next;
    pay_status_t       payload_status_reg,    payload_status_next;

    logic              out_free;
    logic              proc_fire;
    logic              in_load;
    logic [3:0]        cur_type;
    logic              in_payload;
    logic              ovf_set;
    logic              ovf_now;
    logic [CNT_W-1:0]  pay_pos;

    // A byte with no result never waits on the output side.
    assign out_free    = !result_valid_reg || !result_stall;
    assign proc_fire   = in_valid_reg && (!in_last_reg || out_free);
    assign in_load     = frame_valid && !frame_stall;
    assign frame_stall = in_valid_reg && !proc_fire;

    always_comb
    begin
        cur_type   = (byte_count_reg == '0) ? in_data_reg[7:4] : frame_type_reg;
        in_payload = (byte_count_reg >= PAY_OFFSET);
        pay_pos    = byte_count_reg - PAY_OFFSET;
        ovf_set    = in_payload &&
                     ((byte_count_reg == COUNT_MAX) ||
                      ({{(CMP_W-CNT_W){1'b0}}, pay_pos} >= CMP_W'(MAX_PAYLOAD_BYTES)));
        ovf_now    = overflow_flag_reg || ovf_set;

        frame_type_next        = cur_type;
        header_remainder_next  = header_remainder_reg;
        payload_remainder_next = payload_remainder_reg;
        overflow_flag_next     = ovf_now;
        byte_count_next        = (byte_count_reg != COUNT_MAX) ?
                                 byte_count_reg + 1'b1 : byte_count_reg;

        if (byte_count_reg < CNT_W'(2))
            header_remainder_next = crc6_byte(header_remainder_reg, in_data_reg);
        if (in_payload && !ovf_now && has_payload_crc(cur_type))
            payload_remainder_next = crc10_byte(payload_remainder_reg, in_data_reg);

        // The frame total is byte_count plus one, so the length checks use
        // the count before this byte.
        if (byte_count_reg == '0)
        begin
            header_status_next = HDR_SHORT;
            header_crc_next    = '0;
        end
        else
        begin
            header_status_next = HDR_OK;
            header_crc_next    = header_remainder_next;
        end

        payload_crc_next = '0;
        if (cur_type == TYPE_ONE)
            payload_status_next = PAY_TYPE_ONE;
        else if (!has_payload_crc(cur_type))
            payload_status_next = PAY_UNKNOWN;
        else if (byte_count_reg < CNT_W'(3))
            payload_status_next = PAY_TOO_SHORT;
        else if (ovf_now)
            payload_status_next = PAY_TOO_LONG;
        else
        begin
            payload_status_next = PAY_OK;
            payload_crc_next    = payload_remainder_next;
        end

        if (in_last_reg)
        begin
            byte_count_next        = '0;
            frame_type_next        = '0;
            header_remainder_next  = '0;
            payload_remainder_next = '0;
            overflow_flag_next     = 1'b0;
        end

        if (proc_fire && in_last_reg)
            result_valid_next = 1'b1;
        else
            result_valid_next = result_valid_reg && result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            in_last_reg           <= 1'b0;
            byte_count_reg        <= '0;
            frame_type_reg        <= '0;
            header_remainder_reg  <= '0;
            payload_remainder_reg <= '0;
            overflow_flag_reg     <= 1'b0;
            result_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
                in_last_reg  <= last_byte;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire)
            begin
                byte_count_reg        <= byte_count_next;
                frame_type_reg        <= frame_type_next;
                header_remainder_reg  <= header_remainder_next;
                payload_remainder_reg <= payload_remainder_next;
                overflow_flag_reg     <= overflow_flag_next;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            in_data_reg <= data_byte;
        if (proc_fire && in_last_reg)
        begin
            header_crc_reg     <= header_crc_next;
            payload_crc_reg    <= payload_crc_next;
            header_status_reg  <= header_status_next;
            payload_status_reg <= payload_status_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign header_crc     = header_crc_reg;
    assign payload_crc    = payload_crc_reg;
    assign header_status  = header_status_reg;
    assign payload_status = payload_status_reg;

    `IUUP_ASSERT_NEXT(a_state_cleared, proc_fire && in_last_reg, byte_count_reg == '0 && !overflow_flag_reg)
    `IUUP_ASSERT_SAME(a_stall_cause, frame_stall, in_last_reg && result_valid_reg && result_stall)
    `IUUP_ASSERT_SAME(a_pay_crc_zero, result_valid && payload_status != PAY_OK, payload_crc == '0)
    `IUUP_ASSERT_SAME(a_hdr_crc_zero, result_valid && header_status == HDR_SHORT, header_crc == '0)
    `IUUP_ASSERT_SAME(a_pay_status_range, result_valid, payload_status <= PAY_TOO_LONG)

endmodule

@@ tb/sv/tb_iuup_frame_crc_engine.sv @@
// ----------------------------------------------------------------------------
// IuUP frame CRC engine testbench
// Streams IuUP frames into the engine one byte word at a time, predicts the
// header CRC-6, payload CRC-10 and both status codes for every frame, and
// checks each result word against the oldest prediction. Both sides idle at
// random, with a stretch of full-rate traffic in the middle of the run.
// ----------------------------------------------------------------------------
module tb_iuup_frame_crc_engine;
    import iuup_crc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A frame type that carries neither a payload CRC nor the type-one meaning.
    localparam logic [3:0] TYPE_RESERVED = 4'd15;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_word_t;

    typedef struct packed {
        logic [HCRC_W-1:0] hcrc;
        logic [PCRC_W-1:0] pcrc;
        logic              hstat;
        pay_status_t       pstat;
    } crc_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              frame_valid = 1'b0;
    logic              frame_stall;
    logic [7:0]        data_byte = 8'h00;
    logic              last_byte = 1'b0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [HCRC_W-1:0] header_crc;
    logic [PCRC_W-1:0] payload_crc;
    logic              header_status;
    logic [2:0]        payload_status;

    frame_word_t frame_words_q[$];
    crc_result_t frame_results_due[$];
    frame_word_t next_word;
    crc_result_t want;
    int          mismatches = 0;
    int          cyc = 0;
    int          frames_sent = 0;
    int          results_seen = 0;

    // Shadow of the engine's per-frame state.
    logic [CNT_W-1:0]  frame_len = '0;
    logic [3:0]        cur_type = '0;
    logic [HCRC_W-1:0] hdr_rem = '0;
    logic [PCRC_W-1:0] pay_rem = '0;
    logic              overflow = 1'b0;

    iuup_frame_crc_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .header_crc     (header_crc),
        .payload_crc    (payload_crc),
        .header_status  (header_status),
        .payload_status (payload_status)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
        cyc <= cyc + 1;

    function automatic logic [PCRC_W-1:0] crc_msb_first(input logic [PCRC_W-1:0] rem,
                                                        input logic [7:0] b,
                                                        input int w,
                                                        input logic [PCRC_W-1:0] poly);
        logic [PCRC_W-1:0] top;
        logic [PCRC_W-1:0] mask;
        top  = PCRC_W'(1) << (w - 1);
        mask = (PCRC_W'(1) << w) - PCRC_W'(1);
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i])
                rem = rem ^ top;
            if ((rem & top) != 0)
                rem = ((rem << 1) ^ poly) & mask;
            else
                rem = (rem << 1) & mask;
        end
        return rem;
    endfunction

    function automatic logic is_data_type(input logic [3:0] t);
        return (t == TYPE_DATA_0) || (t == TYPE_DATA_14);
    endfunction

    // Outside the quiet window each side holds back at random, with a chance of 16 in 100.
    function automatic logic idle_now();
        if (cyc >= 500 && cyc < 1100)
            return 1'b0;
        return $urandom_range(0, 99) < 16;
    endfunction

    task automatic crc_track_byte(input logic [7:0] b, input logic lst);
        logic [CNT_W-1:0] pos;
        crc_result_t      r;
        pos = frame_len;
        if (pos == 0)
            cur_type = b[7:4];
        if (pos < 2)
            hdr_rem = HCRC_W'(crc_msb_first(PCRC_W'(hdr_rem), b, HCRC_W, PCRC_W'(HDR_POLY)));
        if (pos >= PAY_OFFSET)
        begin
            if (pos >= COUNT_MAX || (32'(pos) - 32'(PAY_OFFSET)) >= MAX_PAYLOAD_BYTES)
                overflow = 1'b1;
            if (!overflow && is_data_type(cur_type))
                pay_rem = crc_msb_first(pay_rem, b, PCRC_W, PAY_POLY);
        end
        if (frame_len < COUNT_MAX)
            frame_len = frame_len + 1'b1;
        if (lst)
        begin
            r.pcrc = '0;
            if (frame_len < 2)
            begin
                r.hstat = HDR_SHORT;
                r.hcrc  = '0;
            end
            else
            begin
                r.hstat = HDR_OK;
                r.hcrc  = hdr_rem;
            end
            if (cur_type == TYPE_ONE)
                r.pstat = PAY_TYPE_ONE;
            else if (!is_data_type(cur_type))
                r.pstat = PAY_UNKNOWN;
            else if (frame_len < PAY_OFFSET)
                r.pstat = PAY_TOO_SHORT;
            else if (overflow)
                r.pstat = PAY_TOO_LONG;
            else
            begin
                r.pstat = PAY_OK;
                r.pcrc  = pay_rem;
            end
            frame_results_due.push_back(r);
            frame_len = '0;
            cur_type  = '0;
            hdr_rem   = '0;
            pay_rem   = '0;
            overflow  = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, exp_val);
        mismatches++;
    endtask

    task automatic push_word(input logic [7:0] b, input logic lst);
        frame_words_q.push_back('{data: b, last: lst});
        if (lst)
            frames_sent++;
    endtask

    // The first byte carries the frame type in its high nibble.
    task automatic add_frame(input logic [3:0] ftype, input int len);
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                push_word({ftype, 4'($urandom_range(0, 15))}, len == 1);
            else
                push_word(8'($urandom), i == len - 1);
        end
    endtask

    // Sender: a word leaves the queue only once the previous one was taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid <= 1'b0;
            data_byte   <= 8'h00;
            last_byte   <= 1'b0;
        end
        else
        begin
            if (frame_valid && !frame_stall)
                crc_track_byte(data_byte, last_byte);
            if (!frame_valid || !frame_stall)
            begin
                if (frame_words_q.size() > 0 && !idle_now())
                begin
                    next_word = frame_words_q.pop_front();
                    frame_valid <= 1'b1;
                    data_byte   <= next_word.data;
                    last_byte   <= next_word.last;
                end
                else
                    frame_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (frame_results_due.size() == 0)
                    report_mismatch("unexpected result word", 1, 0);
                else
                begin
                    want = frame_results_due.pop_front();
                    if (header_crc !== want.hcrc)
                        report_mismatch("header_crc", int'(header_crc), int'(want.hcrc));
                    if (payload_crc !== want.pcrc)
                        report_mismatch("payload_crc", int'(payload_crc), int'(want.pcrc));
                    if (header_status !== want.hstat)
                        report_mismatch("header_status", int'(header_status),
                                        int'(want.hstat));
                    if (payload_status !== want.pstat)
                        report_mismatch("payload_status", int'(payload_status),
                                        int'(want.pstat));
                end
            end
            result_stall <= idle_now();
        end
    end

    initial
    begin
        int len;
        int pick;
        logic [3:0] ftype;

        // Single byte frames, both with a short header: too short, then type one.
        push_word({TYPE_DATA_0, 4'h0}, 1'b1);
        push_word({TYPE_ONE, 4'hF}, 1'b1);
        // Unknown type with all ones in the header.
        push_word({TYPE_RESERVED, 4'hF}, 1'b0);
        push_word(8'hFF, 1'b1);
        // Data type frame that ends before the payload offset.
        push_word({TYPE_DATA_14, 4'h0}, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h55, 1'b1);
        // Exactly four bytes: empty payload.
        push_word({TYPE_DATA_0, 4'h0}, 1'b0);
        push_word(8'hAB, 1'b0);
        push_word(8'hCD, 1'b0);
        push_word(8'hEF, 1'b1);
        push_word({TYPE_DATA_14, 4'h5}, 1'b0);
        push_word(8'h12, 1'b0);
        push_word(8'h34, 1'b0);
        push_word(8'h56, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b1);
        push_word({4'd7, 4'h0}, 1'b0);
        push_word(8'h80, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'h02, 1'b0);
        push_word(8'h03, 1'b1);

        // Payload one byte over the size limit.
        add_frame(TYPE_DATA_14, int'(PAY_OFFSET) + int'(MAX_PAYLOAD_BYTES) + 1);

        while (frame_words_q.size() < 1600)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                ftype = TYPE_DATA_0;
            else if (pick < 70)
                ftype = TYPE_DATA_14;
            else if (pick < 80)
                ftype = TYPE_ONE;
            else
            begin
                ftype = 4'($urandom_range(0, 15));
                if (ftype == TYPE_DATA_0 || ftype == TYPE_DATA_14)
                    ftype = TYPE_RESERVED;
            end
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, 4);
            else
                len = $urandom_range(5, 48);
            add_frame(ftype, len);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (results_seen < frames_sent)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("tb_iuup_frame_crc_engine: done, clean");
        else
            $display("tb_iuup_frame_crc_engine: done, errors");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb_iuup_frame_crc_engine: done, errors");
        $finish;
    end

endmodule
